FILE: rtl/spinor_pkg.sv
// shared types, codes and step numbering for the spi nor command sequencer
package spinor_pkg;

  // input function codes
  typedef enum logic [2:0] {
    FN_INIT  = 3'd0,
    FN_READ  = 3'd1,
    FN_PROG  = 3'd2,
    FN_ERASE = 3'd3,
    FN_DATA  = 3'd4,
    FN_RECV  = 3'd5
  } func_t;

  // result action codes
  typedef enum logic [2:0] {
    ACT_LOW     = 3'd0,
    ACT_HIGH    = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RECV    = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_REPORT  = 3'd5
  } action_t;

  // report status codes
  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_OK     = 3'd1,
    ST_PARAM  = 3'd2,
    ST_NOINIT = 3'd3,
    ST_BUSY   = 3'd4,
    ST_ERROR  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ID    = 4'd1,
    PH_RDATA = 4'd2,
    PH_PDATA = 4'd3,
    PH_POLL  = 4'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_PROG  = 2'd2,
    OP_ERASE = 2'd3
  } op_kind_t;

  // flash command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_FREAD = 8'h0B;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // fixed order of every possible result step, one mask bit each
  localparam int S_DELIVER  = 0;
  localparam int S_SEND_DAT = 1;
  localparam int S_HIGH_A   = 2;
  localparam int S_WD_LOW   = 3;
  localparam int S_WD_SEND  = 4;
  localparam int S_WD_HIGH  = 5;
  localparam int S_WE_LOW   = 6;
  localparam int S_WE_SEND  = 7;
  localparam int S_WE_HIGH  = 8;
  localparam int S_FILL_A   = 9;
  localparam int S_CMD_LOW  = 10;
  localparam int S_CMD      = 11;
  localparam int S_ADDR_H   = 12;
  localparam int S_ADDR_M   = 13;
  localparam int S_ADDR_L   = 14;
  localparam int S_FILL_B   = 15;
  localparam int S_HIGH_B   = 16;
  localparam int S_PL_LOW   = 17;
  localparam int S_PL_SEND  = 18;
  localparam int S_RECV     = 19;
  localparam int S_REPORT   = 20;
  localparam int NSTEP      = 21;
  localparam int STEP_W     = 5;

  typedef logic [NSTEP-1:0] step_mask_t;

  // one queued job: the steps it emits and the values they need
  typedef struct packed {
    step_mask_t  mask;
    logic [23:0] addr;
    logic [7:0]  data;
    logic [7:0]  cmd;
    status_t     status;
  } job_t;

endpackage

FILE: rtl/spinor_front.sv
// front end: accepts items, holds the sequencer state and builds result jobs
module spinor_front import spinor_pkg::*; #(
  parameter int PAGE_LOG2   = 8,
  parameter int SECTOR_LOG2 = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic [2:0]  func,
  input  logic [23:0] address,
  input  logic [24:0] length,
  input  logic [7:0]  data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        push,
  output job_t        job
);

  localparam int CW = PAGE_LOG2 + 1;
  localparam logic [CW-1:0] PAGE_SZ = CW'(1) << PAGE_LOG2;
  localparam logic [24:0] SECTOR_SZ = 25'(1) << SECTOR_LOG2;

  logic [24:0] flash_size;
  logic [31:0] poll_limit;
  logic [23:0] expected_id;

  phase_t      phase, phase_next;
  op_kind_t    op_kind, op_kind_next;
  logic        init_done, init_done_next;
  logic        busy_mark, busy_mark_next;
  logic [23:0] current_address, current_address_next;
  logic [24:0] bytes_remaining, bytes_remaining_next;
  logic [CW-1:0] chunk_left, chunk_left_next;
  logic [31:0] polls_left, polls_left_next;
  logic [23:0] id_shift, id_shift_next;
  logic [1:0]  id_count, id_count_next;

  logic [31:0] poll_start;
  logic [25:0] end_addr;
  status_t     err;
  logic [23:0] ps_addr;
  logic [24:0] ps_len;
  logic [CW-1:0] room, chunk_new, chunk_dec;
  logic [24:0] bytes_dec;
  logic [23:0] erase_addr;
  logic [24:0] erase_len;
  logic [23:0] id_new;
  logic [1:0]  id_cnt_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_size  <= 25'd16777216;
      poll_limit  <= 32'd100000;
      expected_id <= 24'd15679511;
    end else if (cfg_write) begin
      case (cfg_index)
        2'd0:    flash_size  <= cfg_data[24:0];
        2'd1:    poll_limit  <= cfg_data;
        2'd2:    expected_id <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // request check
  assign poll_start = (poll_limit == 32'd0) ? 32'd1 : poll_limit;
  assign end_addr   = {2'b00, address} + {1'b0, length};
  always_comb begin
    if (length == 25'd0 || end_addr > {1'b0, flash_size})
      err = ST_PARAM;
    else if (func == FN_ERASE && (address[SECTOR_LOG2-1:0] != '0 ||
                                  length[SECTOR_LOG2-1:0] != '0))
      err = ST_PARAM;
    else if (!init_done)
      err = ST_NOINIT;
    else if (busy_mark)
      err = ST_BUSY;
    else
      err = ST_NONE;
  end

  // page chunk for a program start
  assign ps_addr   = (func == FN_PROG) ? address : current_address;
  assign ps_len    = (func == FN_PROG) ? length : bytes_remaining;
  assign room      = PAGE_SZ - {1'b0, ps_addr[PAGE_LOG2-1:0]};
  assign chunk_new = (ps_len < {{(25-CW){1'b0}}, room}) ? ps_len[CW-1:0] : room;

  assign bytes_dec  = (bytes_remaining != 25'd0) ? bytes_remaining - 25'd1 : 25'd0;
  assign chunk_dec  = (chunk_left != '0) ? chunk_left - CW'(1) : '0;
  assign erase_addr = current_address + SECTOR_SZ[23:0];
  assign erase_len  = (bytes_remaining >= SECTOR_SZ) ? bytes_remaining - SECTOR_SZ : 25'd0;
  assign id_new     = {id_shift[15:0], data};
  assign id_cnt_inc = id_count + 2'd1;

  // next state and job
  always_comb begin
    phase_next           = phase;
    op_kind_next         = op_kind;
    init_done_next       = init_done;
    busy_mark_next       = busy_mark;
    current_address_next = current_address;
    bytes_remaining_next = bytes_remaining;
    chunk_left_next      = chunk_left;
    polls_left_next      = polls_left;
    id_shift_next        = id_shift;
    id_count_next        = id_count;
    job        = '0;
    job.addr   = current_address;
    job.data   = data;
    job.status = ST_NONE;
    if (acc) begin
      case (func) inside
        FN_INIT: begin
          init_done_next = 1'b0;
          busy_mark_next = 1'b0;
          id_shift_next  = '0;
          id_count_next  = '0;
          phase_next     = PH_ID;
          job.cmd = CMD_RDID;
          job.mask[S_CMD_LOW] = 1'b1;
          job.mask[S_CMD]     = 1'b1;
          job.mask[S_RECV]    = 1'b1;
        end
        FN_READ, FN_PROG, FN_ERASE: begin
          if (err != ST_NONE) begin
            job.mask[S_REPORT] = 1'b1;
            job.status = err;
          end else begin
            busy_mark_next       = 1'b1;
            op_kind_next         = op_kind_t'(func[1:0]);
            current_address_next = address;
            bytes_remaining_next = length;
            job.addr = address;
            if (func == FN_READ) begin
              job.cmd = CMD_FREAD;
              job.mask[S_ADDR_L:S_FILL_A] = '1;
              job.mask[S_FILL_B] = 1'b1;
              job.mask[S_RECV]   = 1'b1;
              phase_next = PH_RDATA;
            end else if (func == FN_PROG) begin
              job.cmd = CMD_PP;
              job.mask[S_ADDR_L:S_WE_LOW] = '1;
              chunk_left_next = chunk_new;
              phase_next = PH_PDATA;
            end else begin
              job.cmd = CMD_SE;
              job.mask[S_ADDR_L:S_WE_LOW] = '1;
              job.mask[S_RECV:S_HIGH_B]   = '1;
              polls_left_next = poll_start;
              phase_next = PH_POLL;
            end
          end
        end
        FN_DATA: begin
          if (phase == PH_PDATA) begin
            job.mask[S_SEND_DAT] = 1'b1;
            current_address_next = current_address + 24'd1;
            bytes_remaining_next = bytes_dec;
            chunk_left_next      = chunk_dec;
            if (chunk_dec == '0) begin
              job.mask[S_HIGH_A] = 1'b1;
              job.mask[S_RECV:S_PL_LOW] = '1;
              polls_left_next = poll_start;
              phase_next = PH_POLL;
            end
          end
        end
        FN_RECV: begin
          case (phase)
            PH_ID: begin
              id_shift_next = id_new;
              if (id_cnt_inc != 2'd3) begin
                id_count_next = id_cnt_inc;
                job.mask[S_RECV] = 1'b1;
              end else begin
                id_count_next = '0;
                job.mask[S_HIGH_A] = 1'b1;
                job.mask[S_REPORT] = 1'b1;
                phase_next = PH_IDLE;
                if (id_new == expected_id) begin
                  init_done_next = 1'b1;
                  job.status = ST_OK;
                end else begin
                  job.status = ST_ERROR;
                end
              end
            end
            PH_RDATA: begin
              job.mask[S_DELIVER] = 1'b1;
              bytes_remaining_next = bytes_dec;
              if (bytes_dec != 25'd0) begin
                job.mask[S_RECV] = 1'b1;
              end else begin
                job.mask[S_HIGH_A] = 1'b1;
                job.mask[S_RECV:S_PL_LOW] = '1;
                polls_left_next = poll_start;
                phase_next = PH_POLL;
              end
            end
            PH_POLL: begin
              job.mask[S_HIGH_A] = 1'b1;
              if (!data[0]) begin
                case (op_kind)
                  OP_READ: begin
                    busy_mark_next = 1'b0;
                    job.mask[S_REPORT] = 1'b1;
                    job.status = ST_OK;
                    phase_next = PH_IDLE;
                  end
                  OP_PROG: begin
                    job.mask[S_WD_HIGH:S_WD_LOW] = '1;
                    if (bytes_remaining != 25'd0) begin
                      job.cmd = CMD_PP;
                      job.mask[S_ADDR_L:S_WE_LOW] = '1;
                      chunk_left_next = chunk_new;
                      phase_next = PH_PDATA;
                    end else begin
                      busy_mark_next = 1'b0;
                      job.mask[S_REPORT] = 1'b1;
                      job.status = ST_OK;
                      phase_next = PH_IDLE;
                    end
                  end
                  default: begin
                    current_address_next = erase_addr;
                    bytes_remaining_next = erase_len;
                    job.addr = erase_addr;
                    job.mask[S_WD_HIGH:S_WD_LOW] = '1;
                    if (erase_len != 25'd0) begin
                      job.cmd = CMD_SE;
                      job.mask[S_ADDR_L:S_WE_LOW] = '1;
                      job.mask[S_RECV:S_HIGH_B]   = '1;
                      polls_left_next = poll_start;
                    end else begin
                      busy_mark_next = 1'b0;
                      job.mask[S_REPORT] = 1'b1;
                      job.status = ST_OK;
                      phase_next = PH_IDLE;
                    end
                  end
                endcase
              end else begin
                polls_left_next = polls_left - 32'd1;
                if (polls_left != 32'd1) begin
                  job.mask[S_RECV:S_PL_LOW] = '1;
                end else begin
                  if (op_kind != OP_READ) busy_mark_next = 1'b0;
                  job.mask[S_REPORT] = 1'b1;
                  job.status = ST_ERROR;
                  phase_next = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign push = acc && (job.mask != '0);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      op_kind         <= OP_NONE;
      init_done       <= 1'b0;
      busy_mark       <= 1'b0;
      current_address <= '0;
      bytes_remaining <= '0;
      chunk_left      <= '0;
      polls_left      <= '0;
      id_shift        <= '0;
      id_count        <= '0;
    end else begin
      phase           <= phase_next;
      op_kind         <= op_kind_next;
      init_done       <= init_done_next;
      busy_mark       <= busy_mark_next;
      current_address <= current_address_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_left      <= chunk_left_next;
      polls_left      <= polls_left_next;
      id_shift        <= id_shift_next;
      id_count        <= id_count_next;
    end
  end

endmodule

FILE: rtl/spinor_queue.sv
// two-entry job queue between front and back
module spinor_queue import spinor_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t rd_job
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_job    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/spinor_back.sv
// back end: walks a job's step mask and emits one result per cycle while out_stall allows
module spinor_back import spinor_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] action,
  output logic [7:0] byte_value,
  output logic [2:0] status,
  output logic       last
);

  job_t             cur;
  logic             cur_valid;
  step_mask_t       low_bit, rest;
  logic [STEP_W-1:0] idx;
  logic             emit;
  action_t          act;
  logic [7:0]       bval;

  // lowest pending step
  assign low_bit = cur.mask & (~cur.mask + step_mask_t'(1));
  assign rest    = cur.mask & ~low_bit;
  always_comb begin
    idx = '0;
    for (int i = 0; i < NSTEP; i++) begin
      if (low_bit[i]) idx = idx | STEP_W'(i);
    end
  end

  // step decoder
  always_comb begin
    act  = ACT_SEND;
    bval = 8'h00;
    unique case (idx) inside
      STEP_W'(S_DELIVER):  begin act = ACT_DELIVER; bval = cur.data; end
      STEP_W'(S_SEND_DAT): bval = cur.data;
      STEP_W'(S_WD_SEND):  bval = CMD_WRDI;
      STEP_W'(S_WE_SEND):  bval = CMD_WREN;
      STEP_W'(S_FILL_A), STEP_W'(S_FILL_B): bval = FILL_BYTE;
      STEP_W'(S_CMD):      bval = cur.cmd;
      STEP_W'(S_ADDR_H):   bval = cur.addr[23:16];
      STEP_W'(S_ADDR_M):   bval = cur.addr[15:8];
      STEP_W'(S_ADDR_L):   bval = cur.addr[7:0];
      STEP_W'(S_PL_SEND):  bval = CMD_RDSR;
      STEP_W'(S_HIGH_A), STEP_W'(S_WD_HIGH), STEP_W'(S_WE_HIGH),
      STEP_W'(S_HIGH_B):   act = ACT_HIGH;
      STEP_W'(S_WD_LOW), STEP_W'(S_WE_LOW), STEP_W'(S_CMD_LOW),
      STEP_W'(S_PL_LOW):   act = ACT_LOW;
      STEP_W'(S_RECV):     act = ACT_RECV;
      STEP_W'(S_REPORT):   act = ACT_REPORT;
      default: ;
    endcase
  end

  assign emit = cur_valid && (!out_valid || !out_stall);
  assign pop  = q_valid && (!cur_valid || (emit && rest == '0));

  // current job
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && rest == '0) begin
      cur_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end else if (emit) begin
      cur.mask <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= cur_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      action     <= act;
      byte_value <= bval;
      status     <= (act == ACT_REPORT) ? cur.status : ST_NONE;
      last       <= (rest == '0);
    end
  end

endmodule

FILE: rtl/spi_nor_flash_command_sequencer.sv
// top level of the spi nor flash command sequencer
//
//  channel | direction | handshake             | payload
//  in      | into      | in_valid / in_stall   | func, address, length, data
//  out     | out of    | out_valid / out_stall | action, byte_value, status, last
//  cfg     | into      | cfg_write             | cfg_index, cfg_data
//
// an item is classified in the cycle it is accepted; one item per clock while the
// two-entry job queue has room.  the back end emits one result per clock while the
// output is not stalled; one item can give up to 17 results (for a poll reply).
// reset is synchronous and clears all control state and restores register defaults.
// out_stall holds the output register and backs up through the queue into in_stall.
module spi_nor_flash_command_sequencer import spinor_pkg::*; #(
  parameter int PAGE_LOG2   = 8,
  parameter int SECTOR_LOG2 = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [23:0] address,
  input  logic [24:0] length,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [7:0]  byte_value,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic acc, push, full, pop, q_valid;
  job_t wr_job, rd_job;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  // front end
  spinor_front #(
    .PAGE_LOG2   (PAGE_LOG2),
    .SECTOR_LOG2 (SECTOR_LOG2)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .func      (func),
    .address   (address),
    .length    (length),
    .data      (data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .job       (wr_job)
  );

  // job queue
  spinor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (wr_job),
    .full      (full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_job    (rd_job)
  );

  // back end
  spinor_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (rd_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .byte_value (byte_value),
    .status     (status),
    .last       (last)
  );

endmodule

FILE: tb/sv/spi_nor_flash_command_sequencer_tb.sv
// self-checking testbench for the spi nor flash command sequencer
module spi_nor_flash_command_sequencer_tb import spinor_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAGE       = 256;
  localparam int          SECTOR     = 4096;
  localparam logic [2:0]  FN_STRAY   = 3'd7;
  localparam logic [1:0]  REG_SIZE   = 2'd0;
  localparam logic [1:0]  REG_POLLS  = 2'd1;
  localparam logic [1:0]  REG_ID     = 2'd2;
  localparam int          DRAIN_WAIT = 60;
  localparam int          PER_PHASE  = 68;

  typedef struct packed {
    action_t     act;
    logic [7:0]  val;
    status_t     st;
    logic        lst;
  } flash_result_t;

  typedef struct packed {
    logic [2:0]  fn;
    logic [23:0] addr;
    logic [24:0] len;
    logic [7:0]  dat;
    logic        typed;
    status_t     typed_st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [23:0] address = '0;
  logic [24:0] length = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [7:0]  byte_value;
  logic [2:0]  status;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spi_nor_flash_command_sequencer u_dut (.*);

  // sequencer mirror: configuration and control state
  logic [24:0] cur_flash_size;
  logic [31:0] cur_poll_limit;
  logic [23:0] cur_id;
  phase_t      seq_phase;
  op_kind_t    seq_op;
  logic        seq_init_done, seq_busy;
  logic [23:0] seq_addr;
  logic [24:0] seq_remaining;
  logic [12:0] seq_chunk;
  logic [31:0] seq_polls;
  logic [23:0] seq_id_shift;
  logic [1:0]  seq_id_count;

  flash_result_t pending_results[$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("[spi_nor_flash_command_sequencer] ERROR");
    $finish;
  end

  // random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      flash_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result act=%0d val=%02h st=%0d last=%0b", $time,
                 action, byte_value, status, last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (action !== want.act || byte_value !== want.val || status !== want.st ||
            last !== want.lst) begin
          $display("%0t: mismatch expected act=%0d val=%02h st=%0d last=%0b", $time,
                   want.act, want.val, want.st, want.lst);
          $display("%0t:          actual   act=%0d val=%02h st=%0d last=%0b", $time,
                   action, byte_value, status, last);
          mismatches++;
        end
      end
    end
  end

  // predictor pieces
  function automatic void emit(action_t a, logic [7:0] v, status_t s);
    pending_results.push_back('{act: a, val: v, st: s, lst: 1'b0});
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    emit(ACT_SEND, v, ST_NONE);
  endfunction

  function automatic void emit_addr();
    emit_byte(seq_addr[23:16]);
    emit_byte(seq_addr[15:8]);
    emit_byte(seq_addr[7:0]);
  endfunction

  function automatic void emit_simple_cmd(logic [7:0] cmd);
    emit(ACT_LOW, 8'h00, ST_NONE);
    emit_byte(cmd);
    emit(ACT_HIGH, 8'h00, ST_NONE);
  endfunction

  function automatic void issue_poll();
    emit(ACT_LOW, 8'h00, ST_NONE);
    emit_byte(CMD_RDSR);
    emit(ACT_RECV, 8'h00, ST_NONE);
  endfunction

  function automatic void begin_poll();
    seq_polls = (cur_poll_limit == 0) ? 32'd1 : cur_poll_limit;
    seq_phase = PH_POLL;
    issue_poll();
  endfunction

  function automatic void report(status_t s);
    emit(ACT_REPORT, 8'h00, s);
    seq_phase = PH_IDLE;
  endfunction

  function automatic void begin_page();
    logic [24:0] room;
    room = 25'(PAGE - (seq_addr % PAGE));
    seq_chunk = (seq_remaining < room) ? seq_remaining[12:0] : room[12:0];
    emit_simple_cmd(CMD_WREN);
    emit_byte(FILL_BYTE);
    emit(ACT_LOW, 8'h00, ST_NONE);
    emit_byte(CMD_PP);
    emit_addr();
    seq_phase = PH_PDATA;
  endfunction

  function automatic void begin_sector();
    emit_simple_cmd(CMD_WREN);
    emit_byte(FILL_BYTE);
    emit(ACT_LOW, 8'h00, ST_NONE);
    emit_byte(CMD_SE);
    emit_addr();
    emit(ACT_HIGH, 8'h00, ST_NONE);
    begin_poll();
  endfunction

  function automatic void status_reply(logic [7:0] sr);
    emit(ACT_HIGH, 8'h00, ST_NONE);
    if (!sr[0]) begin
      if (seq_op == OP_READ) begin
        seq_busy = 1'b0;
        report(ST_OK);
      end else if (seq_op == OP_PROG) begin
        emit_simple_cmd(CMD_WRDI);
        if (seq_remaining > 0) begin
          begin_page();
        end else begin
          seq_busy = 1'b0;
          report(ST_OK);
        end
      end else begin
        seq_addr = 24'(seq_addr + SECTOR);
        seq_remaining = (seq_remaining >= SECTOR) ? 25'(seq_remaining - SECTOR) : '0;
        emit_simple_cmd(CMD_WRDI);
        if (seq_remaining > 0) begin
          begin_sector();
        end else begin
          seq_busy = 1'b0;
          report(ST_OK);
        end
      end
      return;
    end
    seq_polls--;
    if (seq_polls > 0) begin
      issue_poll();
      return;
    end
    if (seq_op != OP_READ) seq_busy = 1'b0;
    report(ST_ERROR);
  endfunction

  function automatic status_t request_verdict(logic [2:0] fn, logic [23:0] a, logic [24:0] n);
    if (n == 0 || ({2'b00, a} + {1'b0, n}) > {1'b0, cur_flash_size}) return ST_PARAM;
    if (fn == FN_ERASE && ((a % SECTOR) != 0 || (n % SECTOR) != 0)) return ST_PARAM;
    if (!seq_init_done) return ST_NOINIT;
    if (seq_busy) return ST_BUSY;
    return ST_NONE;
  endfunction

  // expected results of one accepted transaction; returns how many
  function automatic int predict_sequencer(logic [2:0] fn, logic [23:0] a, logic [24:0] n,
                                           logic [7:0] d);
    int start_count;
    status_t v;
    start_count = pending_results.size();
    if (fn == FN_INIT) begin
      seq_init_done = 1'b0;
      seq_busy = 1'b0;
      seq_id_shift = '0;
      seq_id_count = '0;
      seq_phase = PH_ID;
      emit(ACT_LOW, 8'h00, ST_NONE);
      emit_byte(CMD_RDID);
      emit(ACT_RECV, 8'h00, ST_NONE);
    end else if (fn == FN_READ || fn == FN_PROG || fn == FN_ERASE) begin
      v = request_verdict(fn, a, n);
      if (v != ST_NONE) begin
        emit(ACT_REPORT, 8'h00, v);
      end else begin
        seq_busy = 1'b1;
        seq_op = op_kind_t'(fn[1:0]);
        seq_addr = a;
        seq_remaining = n;
        if (fn == FN_READ) begin
          emit_byte(FILL_BYTE);
          emit(ACT_LOW, 8'h00, ST_NONE);
          emit_byte(CMD_FREAD);
          emit_addr();
          emit_byte(FILL_BYTE);
          emit(ACT_RECV, 8'h00, ST_NONE);
          seq_phase = PH_RDATA;
        end else if (fn == FN_PROG) begin
          begin_page();
        end else begin
          begin_sector();
        end
      end
    end else if (fn == FN_DATA) begin
      if (seq_phase == PH_PDATA) begin
        emit_byte(d);
        seq_addr = seq_addr + 24'd1;
        if (seq_remaining > 0) seq_remaining--;
        if (seq_chunk > 0) seq_chunk--;
        if (seq_chunk == 0) begin
          emit(ACT_HIGH, 8'h00, ST_NONE);
          begin_poll();
        end
      end
    end else if (fn == FN_RECV) begin
      if (seq_phase == PH_ID) begin
        seq_id_shift = {seq_id_shift[15:0], d};
        seq_id_count++;
        if (seq_id_count < 3) begin
          emit(ACT_RECV, 8'h00, ST_NONE);
        end else begin
          seq_id_count = '0;
          emit(ACT_HIGH, 8'h00, ST_NONE);
          if (seq_id_shift == cur_id) begin
            seq_init_done = 1'b1;
            report(ST_OK);
          end else begin
            report(ST_ERROR);
          end
        end
      end else if (seq_phase == PH_RDATA) begin
        emit(ACT_DELIVER, d, ST_NONE);
        if (seq_remaining > 0) seq_remaining--;
        if (seq_remaining > 0) begin
          emit(ACT_RECV, 8'h00, ST_NONE);
        end else begin
          emit(ACT_HIGH, 8'h00, ST_NONE);
          begin_poll();
        end
      end else if (seq_phase == PH_POLL) begin
        status_reply(d);
      end
    end
    if (pending_results.size() > start_count)
      pending_results[pending_results.size()-1].lst = 1'b1;
    return pending_results.size() - start_count;
  endfunction

  // drive one transaction and predict once it is taken
  task automatic send_item(logic [2:0] fn, logic [23:0] a, logic [24:0] n, logic [7:0] d,
                           output int produced);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    func <= fn;
    address <= a;
    length <= n;
    data <= d;
    do @(posedge clk); while (in_stall);
    items_sent++;
    produced = predict_sequencer(fn, a, n, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_SIZE) cur_flash_size = val[24:0];
    else if (idx == REG_POLLS) cur_poll_limit = val;
    else cur_id = val[23:0];
  endtask

  task automatic configure(logic [24:0] sz, logic [31:0] polls, logic [23:0] id);
    write_reg(REG_SIZE, {7'd0, sz});
    write_reg(REG_POLLS, polls);
    write_reg(REG_ID, {8'd0, id});
    cfg_write <= 1'b0;
  endtask

  // one random transaction shaped by where the sequencer currently is
  task automatic random_item(output int produced);
    logic [2:0]  fn;
    logic [23:0] a;
    logic [24:0] n;
    logic [7:0]  d;
    longint      span;
    int          r;
    fn = FN_STRAY;
    a = 24'($urandom);
    n = 25'($urandom);
    d = 8'($urandom);
    r = $urandom_range(99);
    if (r < 7) begin
      fn = 3'($urandom_range(0, 7));
    end else if (seq_phase == PH_ID) begin
      fn = FN_RECV;
      if ($urandom_range(9) != 0) d = 8'(cur_id >> (8 * (2 - seq_id_count)));
    end else if (seq_phase == PH_RDATA) begin
      fn = FN_RECV;
    end else if (seq_phase == PH_PDATA) begin
      fn = FN_DATA;
    end else if (seq_phase == PH_POLL) begin
      fn = FN_RECV;
      if ($urandom_range(3) != 0) d[0] = 1'b0;
      else d[0] = 1'b1;
    end else if ((!seq_init_done || seq_busy) && $urandom_range(2) == 0) begin
      fn = FN_INIT;
    end else begin
      r = $urandom_range(99);
      if (r < 8) begin
        fn = FN_INIT;
      end else if (r < 40) begin
        fn = FN_READ;
        n = 25'($urandom_range(1, 6));
      end else if (r < 75) begin
        fn = FN_PROG;
        n = ($urandom_range(19) == 0) ? 25'($urandom_range(1, 300)) :
                                        25'($urandom_range(1, 12));
      end else begin
        fn = FN_ERASE;
        n = 25'(SECTOR * $urandom_range(1, 2));
      end
      span = longint'(cur_flash_size) - longint'(n);
      if (fn == FN_ERASE) begin
        a = (span >= 0) ? 24'(SECTOR * $urandom_range(0, 32'(span / SECTOR))) : '0;
      end else if (span >= 0) begin
        a = 24'($urandom % (span + 1));
        if ($urandom_range(3) == 0 && span >= PAGE) a[7:0] = 8'(8'hFF - $urandom_range(3));
      end
    end
    send_item(fn, a, n, d, produced);
  endtask

  task automatic random_phase(int idle, int stall);
    int produced;
    int useful;
    sender_idle_pct = idle;
    stall_pct = stall;
    useful = 0;
    while (useful < PER_PHASE) begin
      random_item(produced);
      if (produced > 0) useful++;
    end
    drain();
  endtask

  // directed table: typed rows carry their single report status
  dir_row_t dir_tab [0:33] = '{
    '{FN_READ,  24'h000000, 25'd16,       8'h00, 1'b1, ST_NOINIT},
    '{FN_PROG,  24'h000000, 25'd0,        8'h00, 1'b1, ST_PARAM},
    '{FN_ERASE, 24'h000100, 25'd4096,     8'h00, 1'b1, ST_PARAM},
    '{FN_ERASE, 24'h001000, 25'd100,      8'h00, 1'b1, ST_PARAM},
    '{FN_READ,  24'hFFFFFF, 25'd2,        8'h00, 1'b1, ST_PARAM},
    '{FN_READ,  24'h000000, 25'h1000000,  8'h00, 1'b1, ST_NOINIT},
    '{FN_DATA,  24'h000000, 25'd0,        8'hAA, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h55, 1'b0, ST_NONE},
    '{FN_STRAY, 24'hFFFFFF, 25'h1FFFFFF,  8'hFF, 1'b0, ST_NONE},
    '{FN_INIT,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'hEF, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h40, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h17, 1'b0, ST_NONE},
    '{FN_READ,  24'hFFFFFE, 25'd2,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'hA5, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h5A, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h01, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_PROG,  24'h0000FE, 25'd3,        8'h00, 1'b0, ST_NONE},
    '{FN_DATA,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_DATA,  24'h000000, 25'd0,        8'hFF, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_DATA,  24'h000000, 25'd0,        8'h80, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'hFE, 1'b0, ST_NONE},
    '{FN_ERASE, 24'hFFE000, 25'd8192,     8'h00, 1'b0, ST_NONE},
    '{FN_READ,  24'h000000, 25'd1,        8'h00, 1'b1, ST_BUSY},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_INIT,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_RECV,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE},
    '{FN_PROG,  24'h000000, 25'd1,        8'h00, 1'b1, ST_NOINIT},
    '{FN_INIT,  24'h000000, 25'd0,        8'h00, 1'b0, ST_NONE}
  };

  // main sequence
  initial begin
    int produced;
    cur_flash_size = 25'h1000000;
    cur_poll_limit = 32'd100000;
    cur_id = 24'hEF4017;
    seq_phase = PH_IDLE;
    seq_op = OP_NONE;
    seq_init_done = 1'b0;
    seq_busy = 1'b0;
    seq_addr = '0;
    seq_remaining = '0;
    seq_chunk = '0;
    seq_polls = '0;
    seq_id_shift = '0;
    seq_id_count = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk, defaults after reset
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].fn, dir_tab[i].addr, dir_tab[i].len, dir_tab[i].dat, produced);
      if (dir_tab[i].typed) begin
        repeat (produced) void'(pending_results.pop_back());
        pending_results.push_back('{act: ACT_REPORT, val: 8'h00, st: dir_tab[i].typed_st,
                                    lst: 1'b1});
      end
    end
    drain();

    configure(25'h1000000, 32'd3, 24'hEF4017);
    random_phase(0, 0);
    configure(25'd1, 32'd0, 24'h000000);
    random_phase(60, 0);
    configure(25'h0123456, 32'hFFFFFFFF, 24'hFFFFFF);
    random_phase(0, 60);
    configure(25'h1000000, 32'd2, 24'hA5C3E1);
    random_phase(11, 11);

    $display("covered %0d transactions in, %0d results out", items_sent, results_seen);
    $display("four register settings, idle and stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("[spi_nor_flash_command_sequencer] OK");
    end else begin
      $display("[spi_nor_flash_command_sequencer] ERROR");
    end
    $finish;
  end

endmodule
